// File: rtl/cht_pkg.sv
package cht_pkg;

  localparam int unsigned MaxSlots   = 16;
  localparam int unsigned SlotW      = $clog2(MaxSlots);
  localparam int unsigned SizeW      = 5;
  localparam int unsigned KeyW       = 31;
  localparam int unsigned QuoW       = KeyW;
  localparam int unsigned BitW       = $clog2(QuoW);
  localparam int unsigned RoundW     = $clog2(MaxSlots + 1);
  localparam int unsigned AddrW      = 1;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);
  localparam logic [AddrW-1:0] RegTableSize = AddrW'(0);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [KeyW-1:0] dropped_key;
    logic            full_res;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request key into cur
    logic div_start; // start dividing cur by size
    logic div_step;  // one restoring-division step
    logic t1_probe;  // act on table one at slot of cur
    logic t2_probe;  // act on table two at slot of cur
    logic del_try;   // attempt delete
    logic finish;    // latch result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic placed;    // last probe found an empty slot, or last delete found the key
  } sts_t;

endpackage

// File: rtl/cht_datapath.sv
module cht_datapath import cht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  req_t             req_i,
  input  logic [SizeW-1:0] size_i,
  output sts_t             sts_o,
  output rsp_t             rsp_o
);

  logic [KeyW-1:0]     t1_key_q [MaxSlots];
  logic [KeyW-1:0]     t2_key_q [MaxSlots];
  logic [MaxSlots-1:0] t1_vld_q, t2_vld_q;
  logic [KeyW-1:0]     cur_q, key_q;
  logic [QuoW-1:0]     quo_q;
  logic [SizeW-1:0]    rem_q;
  logic [BitW-1:0]     bit_q;
  logic                div_busy_q;
  logic                placed_q;
  logic                phase_q;
  logic [SlotW-1:0]    p1_q, p2_q;
  rsp_t                rsp_q;

  // Effective size clamped to 1..MaxSlots.
  logic [SizeW-1:0] s_eff;
  always_comb begin
    if (size_i == '0) s_eff = SizeW'(1);
    else if (size_i > SizeW'(MaxSlots)) s_eff = SizeW'(MaxSlots);
    else s_eff = size_i;
  end

  // One restoring-division step: shift in the next dividend bit, subtract when it fits.
  logic [SizeW:0] rem_sh;
  logic [SizeW:0] rem_nx;
  logic           ge;
  logic           last_bit;
  always_comb begin
    rem_sh = {rem_q, quo_q[QuoW-1]};
    ge     = rem_sh >= {1'b0, s_eff};
    rem_nx = ge ? rem_sh - {1'b0, s_eff} : rem_sh;
  end
  assign last_bit = (bit_q == BitW'(QuoW - 1));

  logic full;
  always_comb begin
    full = 1'b1;
    for (int i = 0; i < MaxSlots; i++) begin
      if (i < int'(s_eff) && (!t1_vld_q[i] || !t2_vld_q[i])) full = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q   <= '0;
      t2_vld_q   <= '0;
      cur_q      <= '0;
      key_q      <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      bit_q      <= '0;
      div_busy_q <= 1'b0;
      placed_q   <= 1'b0;
      phase_q    <= 1'b0;
      p1_q       <= '0;
      p2_q       <= '0;
    end else if (cmd_i.load) begin
      cur_q <= req_i.key;
      key_q <= req_i.key;
    end else if (cmd_i.div_start) begin
      quo_q      <= cur_q;
      rem_q      <= '0;
      bit_q      <= '0;
      phase_q    <= 1'b0;
      div_busy_q <= 1'b1;
    end else if (cmd_i.div_step && div_busy_q) begin
      if (!last_bit) begin
        quo_q <= {quo_q[QuoW-2:0], ge};
        rem_q <= rem_nx[SizeW-1:0];
        bit_q <= bit_q + BitW'(1);
      end else if (!phase_q) begin
        // First pass done: remainder is slot one, quotient feeds the second pass.
        p1_q    <= rem_nx[SlotW-1:0];
        quo_q   <= {quo_q[QuoW-2:0], ge};
        rem_q   <= '0;
        bit_q   <= '0;
        phase_q <= 1'b1;
      end else begin
        p2_q       <= rem_nx[SlotW-1:0];
        div_busy_q <= 1'b0;
      end
    end else if (cmd_i.t1_probe) begin
      if (!t1_vld_q[p1_q]) begin
        t1_vld_q[p1_q] <= 1'b1;
        placed_q       <= 1'b1;
      end else begin
        cur_q    <= t1_key_q[p1_q];
        placed_q <= 1'b0;
      end
    end else if (cmd_i.t2_probe) begin
      if (!t2_vld_q[p2_q]) begin
        t2_vld_q[p2_q] <= 1'b1;
        placed_q       <= 1'b1;
      end else begin
        cur_q    <= t2_key_q[p2_q];
        placed_q <= 1'b0;
      end
    end else if (cmd_i.del_try) begin
      if (t1_vld_q[p1_q] && t1_key_q[p1_q] == key_q) begin
        t1_vld_q[p1_q] <= 1'b0;
        placed_q       <= 1'b1;
      end else if (t2_vld_q[p2_q] && t2_key_q[p2_q] == key_q) begin
        t2_vld_q[p2_q] <= 1'b0;
        placed_q       <= 1'b1;
      end else begin
        placed_q <= 1'b0;
      end
    end
  end

  // Key storage: a probe always leaves cur in its slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.t1_probe) t1_key_q[p1_q] <= cur_q;
    if (cmd_i.t2_probe) t2_key_q[p2_q] <= cur_q;
  end

  // Result latches on finish, after the last table update has taken effect, so full is current.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.full_res <= full;
      if (req_i.cmd == CMD_DELETE) begin
        rsp_q.status      <= placed_q ? ST_DELETED : ST_NOT_FOUND;
        rsp_q.dropped_key <= '0;
      end else begin
        rsp_q.status      <= placed_q ? ST_INSERTED : ST_DROPPED;
        rsp_q.dropped_key <= placed_q ? '0 : cur_q;
      end
    end
  end

  assign sts_o.div_done = !div_busy_q;
  assign sts_o.placed   = placed_q;
  assign rsp_o          = rsp_q;

endmodule

// File: rtl/cht_ctrl.sv
module cht_ctrl import cht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [SizeW-1:0] size_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o,
  output req_t             req_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_LOAD  = 9'b0_0000_0010,
    S_START = 9'b0_0000_0100,
    S_DIV   = 9'b0_0000_1000,
    S_T1    = 9'b0_0001_0000,
    S_T2    = 9'b0_0010_0000,
    S_CHECK = 9'b0_0100_0000,
    S_DEL   = 9'b0_1000_0000,
    S_FIN   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic   side_q, side_d; // 0 next probe table one, 1 table two
  logic [RoundW-1:0] round_q, round_d, round_nx;
  logic   out_valid_q, out_valid_d;
  logic [SizeW-1:0] s_eff;
  logic   accept;

  always_comb begin
    if (size_i == '0) s_eff = SizeW'(1);
    else if (size_i > SizeW'(MaxSlots)) s_eff = SizeW'(MaxSlots);
    else s_eff = size_i;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign round_nx   = round_q + RoundW'(1);

  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    round_d     = round_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        round_d    = '0;
        side_d     = 1'b0;
        state_d    = S_START;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_done) cmd_o.div_step = 1'b1;
        else if (req_q.cmd == CMD_DELETE) state_d = S_DEL;
        else if (side_q) state_d = S_T2;
        else state_d = S_T1;
      end
      S_T1: begin
        cmd_o.t1_probe = 1'b1;
        state_d        = S_CHECK;
      end
      S_T2: begin
        cmd_o.t2_probe = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.placed) begin
          state_d = S_FIN;
        end else if (!side_q) begin
          side_d  = 1'b1;
          state_d = S_START;
        end else begin
          round_d = round_nx;
          side_d  = 1'b0;
          state_d = (round_nx >= RoundW'(s_eff)) ? S_FIN : S_START;
        end
      end
      S_DEL: begin
        cmd_o.del_try = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
  end

  assign out_valid_o = out_valid_q;
  assign req_o       = req_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOAD) else $error("accept did not start item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q) else $error("stalled result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= RoundW'(MaxSlots)) else $error("round overflow");

endmodule

// File: rtl/cuckoo_hash_table_core.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid_i/stall_o | req_t  (cmd, key)
// out     | output    | out_valid_o/stall_i| rsp_t  (status, dropped_key, full_res)
// cfg     | input     | APB psel/penable   | table_size at byte address 0
//
// Each probe runs the shared serial divider twice (31 steps for slot one, 31
// for slot two), then passes through one probe state and one check state.
// Delete: one divider run, then the delete and finish states.
// Insert: up to 2*size probes before the result, one item at a time.
// Reset clears valid bits and the controller; table_size returns to 16.
// A stalled result holds; the next item is accepted, but its result waits
// until the result register drains.
module cuckoo_hash_table_core import cht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW+1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SizeW-1:0] size_q;
  cmd_t cmd;
  sts_t sts;
  req_t req;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeReset;
    else if (psel && penable && pwrite && paddr[AddrW+1:2] == RegTableSize)
      size_q <= pwdata[SizeW-1:0];
  end
  assign prdata = (paddr[AddrW+1:2] == RegTableSize) ? {27'd0, size_q} : '0;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .size_i(size_q), .sts_i(sts),
    .cmd_o(cmd), .req_o(req)
  );

  cht_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(req), .size_i(size_q),
    .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

// File: sim/tb_cuckoo_hash_table_core.sv
module tb_cuckoo_hash_table_core;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TailCycles = 3000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  req_t             in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rsp_t             out_data_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW+1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  cuckoo_hash_table_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the hash tables and the size register.
  logic [KeyW-1:0] t1_key [MaxSlots];
  logic            t1_vld [MaxSlots];
  logic [KeyW-1:0] t2_key [MaxSlots];
  logic            t2_vld [MaxSlots];
  logic [SizeW-1:0] size_reg = SizeReset;

  req_t  pending_reqs[$];
  rsp_t  expected_rsps[$];
  int    n_errors = 0;
  bit    quiet = 1'b0;   // no idling on either side once set
  bit    in_taken = 1'b0; // item on the input was accepted at the last edge
  int    in_gap = 0;
  int    out_gap = 0;

  // Compute the response of one request and update the shadow tables.
  function automatic rsp_t hash_apply(req_t r);
    int unsigned s, p1, p2, rnd;
    logic [KeyW-1:0] cur, tmp;
    bit placed;
    rsp_t rsp;
    s = (size_reg == 0) ? 1 : (size_reg > MaxSlots ? MaxSlots : size_reg);
    rsp = '0;
    if (r.cmd == CMD_INSERT) begin
      cur = r.key;
      placed = 1'b0;
      for (rnd = 0; rnd < s && !placed; rnd++) begin
        p1 = cur % s;
        if (!t1_vld[p1]) begin
          t1_key[p1] = cur;
          t1_vld[p1] = 1'b1;
          placed = 1'b1;
        end else begin
          tmp = t1_key[p1];
          t1_key[p1] = cur;
          cur = tmp;
          p2 = (cur / s) % s;
          if (!t2_vld[p2]) begin
            t2_key[p2] = cur;
            t2_vld[p2] = 1'b1;
            placed = 1'b1;
          end else begin
            tmp = t2_key[p2];
            t2_key[p2] = cur;
            cur = tmp;
          end
        end
      end
      if (placed) begin
        rsp.status = ST_INSERTED;
      end else begin
        rsp.status = ST_DROPPED;
        rsp.dropped_key = cur;
      end
    end else begin
      p1 = r.key % s;
      p2 = (r.key / s) % s;
      if (t1_vld[p1] && t1_key[p1] == r.key) begin
        t1_vld[p1] = 1'b0;
        rsp.status = ST_DELETED;
      end else if (t2_vld[p2] && t2_key[p2] == r.key) begin
        t2_vld[p2] = 1'b0;
        rsp.status = ST_DELETED;
      end else begin
        rsp.status = ST_NOT_FOUND;
      end
    end
    rsp.full_res = 1'b1;
    for (int i = 0; i < s; i++) begin
      if (!t1_vld[i] || !t2_vld[i]) rsp.full_res = 1'b0;
    end
    return rsp;
  endfunction

  // Request driver: predict at the accepting edge, advance on the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_rsps.push_back(hash_apply(in_data_i));
      void'(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the stalled item
    end else if (in_gap > 0) begin
      in_taken = 1'b0;
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_taken = 1'b0;
      in_valid_i <= 1'b1;
      in_data_i <= pending_reqs[0];
      if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
    end else begin
      in_taken = 1'b0;
      in_valid_i <= 1'b0;
    end
  end

  // Response monitor and random stall on the output side.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_data_o);
        n_errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data_o.status);
          n_errors++;
        end
        if (out_data_o.dropped_key !== exp_rsp.dropped_key) begin
          $error("dropped_key: expected %0h, got %0h",
                 exp_rsp.dropped_key, out_data_o.dropped_key);
          n_errors++;
        end
        if (out_data_o.full_res !== exp_rsp.full_res) begin
          $error("full_res: expected %0b, got %0b", exp_rsp.full_res, out_data_o.full_res);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 11) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Wait until every queued request has been answered.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // APB write of the size register; only called with the block idle.
  task automatic set_size(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {RegTableSize, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    size_reg = value[SizeW-1:0];
  endtask

  function automatic void push_req(cmd_e c, logic [KeyW-1:0] k);
    req_t r;
    r.cmd = c;
    r.key = k;
    pending_reqs.push_back(r);
  endfunction

  // Pick a key that is mostly small (0 to 300), sometimes anywhere in the key range.
  function automatic logic [KeyW-1:0] rand_key();
    if ($urandom_range(0, 7) == 0) return KeyW'({$urandom, $urandom});
    return KeyW'($urandom_range(0, 300));
  endfunction

  initial begin
    logic [KeyW-1:0] used [$];
    int sizes [7] = '{16, 1, 0, 4, 31, 2, 9};
    for (int i = 0; i < MaxSlots; i++) begin
      t1_vld[i] = 1'b0;
      t2_vld[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, deletes hitting either table and missing.
    push_req(CMD_INSERT, '0);
    push_req(CMD_INSERT, '1);
    push_req(CMD_INSERT, '0);          // duplicate key
    push_req(CMD_DELETE, '0);
    push_req(CMD_DELETE, '0);          // second copy now from table two
    push_req(CMD_DELETE, '0);          // not found
    push_req(CMD_DELETE, 31'h5555_5555);
    push_req(CMD_INSERT, 31'h2AAA_AAAA);
    push_req(CMD_DELETE, '1);
    drain();
    set_size(1);                       // tiny table: fill, drop, full flag
    for (int i = 0; i < 4; i++) push_req(CMD_INSERT, KeyW'(i * 7));
    push_req(CMD_DELETE, 31'd7);
    push_req(CMD_DELETE, 31'd99);
    drain();
    set_size(0);                       // zero acts as one
    push_req(CMD_INSERT, 31'd3);
    push_req(CMD_DELETE, 31'd14);
    drain();
    set_size(31);                      // clamps to the maximum; old entries remain
    push_req(CMD_DELETE, 31'd0);
    push_req(CMD_INSERT, 31'd16);
    drain();

    // Random phases across sizes; one full pause per phase via drain.
    for (int ph = 0; ph < 7; ph++) begin
      set_size(sizes[ph]);
      if (ph == 6) quiet = 1'b1;
      for (int n = 0; n < 235; n++) begin
        if (used.size() > 0 && $urandom_range(0, 2) == 0) begin
          push_req(CMD_DELETE, used[$urandom_range(0, used.size() - 1)]);
        end else if ($urandom_range(0, 9) == 0) begin
          push_req(CMD_DELETE, rand_key());
        end else begin
          used.push_back(rand_key());
          if (used.size() > 64) void'(used.pop_front());
          push_req(CMD_INSERT, used[$]);
        end
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("tb_cuckoo_hash_table_core: done, clean");
    end else begin
      $display("tb_cuckoo_hash_table_core: done, errors");
    end
    $finish;
  end

  // Worst case about 1700 items * 32 probes at a 12 ns clock period, taken over.
  initial begin
    #300ms;
    $display("tb_cuckoo_hash_table_core: done, errors");
    $finish;
  end

endmodule
